/* sv/fgemv_pkg.sv */
`timescale 1ns / 1ps

package fgemv_pkg;

  // vector store geometry
  localparam int unsigned MAX_LENGTH = 1024;
  localparam int unsigned VEC_AW     = $clog2(MAX_LENGTH);
  localparam int unsigned LEN_W      = VEC_AW + 1;

  // binary32 codes
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] EXP_ALL   = 32'h7F80_0000;

  typedef enum logic {
    ActLoad   = 1'b0,
    ActWeight = 1'b1
  } action_e;

  typedef enum logic {
    RegVecLen   = 1'b0,
    RegRowTotal = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        action;
    logic [9:0]  x_index;
    logic [31:0] value_bits;
  } in_item_t;

  typedef struct packed {
    logic [31:0] dot_bits;
    logic [9:0]  row_number;
    logic        last_row;
  } out_item_t;

  // row bookkeeping that rides along with a weight through the datapath
  typedef struct packed {
    logic       eor;
    logic [9:0] row;
    logic       last;
  } row_meta_t;

endpackage

/* sv/fgemv_fma.sv */
`timescale 1ns / 1ps

module fgemv_fma (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 v_i,
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  input  fgemv_pkg::row_meta_t meta_i,
  input  logic [31:0]          c_i,
  output logic                 busy_o,
  output logic                 v_o,
  output logic [31:0]          bits_o,
  output fgemv_pkg::row_meta_t meta_o
);

  localparam logic signed [11:0] SubExp   = -12'sd149;
  localparam logic signed [11:0] ExpBias  = 12'sd150;
  localparam logic signed [11:0] PackBias = 12'sd175;
  localparam logic signed [11:0] SubNet   = 12'sd174;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sign;
  } pflags_t;

  // leading zero count of a 49-bit word
  function automatic logic [5:0] lzc49(input logic [48:0] v);
    logic [5:0] n;
    n = 6'd49;
    for (int i = 0; i < 49; i++) begin
      if (v[i]) n = 6'(48 - i);
    end
    return n;
  endfunction

  // ---------------- stage 2: classify and multiply
  logic [7:0]         fa, fb;
  logic [23:0]        ma, mb;
  logic signed [11:0] ea, eb;
  logic               anan, bnan, ainf, binf, az, bz;
  pflags_t            pf2_d;

  always_comb begin
    fa   = a_i[30:23];
    fb   = b_i[30:23];
    ma   = (fa == 8'd0) ? {1'b0, a_i[22:0]} : {1'b1, a_i[22:0]};
    mb   = (fb == 8'd0) ? {1'b0, b_i[22:0]} : {1'b1, b_i[22:0]};
    ea   = (fa == 8'd0) ? SubExp : $signed({4'd0, fa}) - ExpBias;
    eb   = (fb == 8'd0) ? SubExp : $signed({4'd0, fb}) - ExpBias;
    anan = a_i[30:0] > fgemv_pkg::EXP_ALL[30:0];
    bnan = b_i[30:0] > fgemv_pkg::EXP_ALL[30:0];
    ainf = a_i[30:0] == fgemv_pkg::EXP_ALL[30:0];
    binf = b_i[30:0] == fgemv_pkg::EXP_ALL[30:0];
    az   = a_i[30:0] == 31'd0;
    bz   = b_i[30:0] == 31'd0;
    pf2_d.nan  = anan | bnan | (ainf & bz) | (binf & az);
    pf2_d.inf  = ainf | binf;
    pf2_d.zero = az | bz;
    pf2_d.sign = a_i[31] ^ b_i[31];
  end

  logic                 v2_q;
  logic [47:0]          pm2_q;
  logic signed [11:0]   pe2_q;
  pflags_t              pf2_q;
  fgemv_pkg::row_meta_t meta2_q;

  always_ff @(posedge clk_i) begin
    pm2_q   <= ma * mb;
    pe2_q   <= ea + eb;
    pf2_q   <= pf2_d;
    meta2_q <= meta_i;
  end

  // ---------------- stage 3: leading zeros of the product
  logic                 v3_q;
  logic [47:0]          pm3_q;
  logic signed [11:0]   pe3_q;
  logic [5:0]           lz3_q;
  pflags_t              pf3_q;
  fgemv_pkg::row_meta_t meta3_q;

  always_ff @(posedge clk_i) begin
    pm3_q   <= pm2_q;
    pe3_q   <= pe2_q;
    lz3_q   <= lzc49({pm2_q, 1'b0});
    pf3_q   <= pf2_q;
    meta3_q <= meta2_q;
  end

  // ---------------- stage 4: normalize the product to bit 47
  logic                 v4_q;
  logic [47:0]          pm4_q;
  logic signed [11:0]   pe4_q;
  pflags_t              pf4_q;
  fgemv_pkg::row_meta_t meta4_q;

  always_ff @(posedge clk_i) begin
    pm4_q   <= pm3_q << lz3_q;
    pe4_q   <= pe3_q - $signed({6'd0, lz3_q});
    pf4_q   <= pf3_q;
    meta4_q <= meta3_q;
  end

  // ---------------- stage 5: read the running sum, special cases, normalize addend
  logic [7:0]         fc;
  logic [23:0]        cmr;
  logic signed [11:0] cer;
  logic [5:0]         lzc_c;
  logic               cnan, cinf, cz;
  logic               spec5_d;
  logic [31:0]        sbits5_d;

  always_comb begin
    fc    = c_i[30:23];
    cmr   = (fc == 8'd0) ? {1'b0, c_i[22:0]} : {1'b1, c_i[22:0]};
    cer   = (fc == 8'd0) ? SubExp : $signed({4'd0, fc}) - ExpBias;
    lzc_c = lzc49({cmr, 25'd0});
    cnan  = c_i[30:0] > fgemv_pkg::EXP_ALL[30:0];
    cinf  = c_i[30:0] == fgemv_pkg::EXP_ALL[30:0];
    cz    = c_i[30:0] == 31'd0;
    spec5_d  = 1'b1;
    sbits5_d = fgemv_pkg::CANON_NAN;
    priority if (pf4_q.nan || cnan) begin
      sbits5_d = fgemv_pkg::CANON_NAN;
    end else if (pf4_q.inf) begin
      sbits5_d = (cinf && (c_i[31] != pf4_q.sign)) ? fgemv_pkg::CANON_NAN
                                                  : {pf4_q.sign, fgemv_pkg::EXP_ALL[30:0]};
    end else if (cinf) begin
      sbits5_d = c_i;
    end else if (pf4_q.zero) begin
      sbits5_d = cz ? {pf4_q.sign & c_i[31], 31'd0} : c_i;
    end else begin
      spec5_d = 1'b0;
    end
  end

  logic                 v5_q;
  logic [47:0]          pm5_q, cm5_q;
  logic signed [11:0]   pe5_q, ce5_q;
  logic                 ps5_q, cs5_q, cz5_q;
  logic                 spec5_q;
  logic [31:0]          sbits5_q;
  fgemv_pkg::row_meta_t meta5_q;

  always_ff @(posedge clk_i) begin
    pm5_q    <= pm4_q;
    pe5_q    <= pe4_q;
    ps5_q    <= pf4_q.sign;
    cm5_q    <= {cmr, 24'd0} << lzc_c;
    ce5_q    <= cer - 12'sd24 - $signed({6'd0, lzc_c});
    cs5_q    <= c_i[31];
    cz5_q    <= cz;
    spec5_q  <= spec5_d;
    sbits5_q <= sbits5_d;
    meta5_q  <= meta4_q;
  end

  // ---------------- stage 6: order operands by magnitude
  logic               pbig;
  logic signed [11:0] dexp;

  always_comb begin
    pbig = cz5_q || (pe5_q > ce5_q) || ((pe5_q == ce5_q) && (pm5_q >= cm5_q));
    dexp = pbig ? (pe5_q - ce5_q) : (ce5_q - pe5_q);
  end

  logic                 v6_q;
  logic [47:0]          big6_q, small6_q;
  logic signed [11:0]   be6_q;
  logic                 bs6_q, sub6_q;
  logic [5:0]           d6_q;
  logic                 spec6_q;
  logic [31:0]          sbits6_q;
  fgemv_pkg::row_meta_t meta6_q;

  always_ff @(posedge clk_i) begin
    big6_q   <= pbig ? pm5_q : cm5_q;
    small6_q <= cz5_q ? 48'd0 : (pbig ? cm5_q : pm5_q);
    be6_q    <= pbig ? pe5_q : ce5_q;
    bs6_q    <= pbig ? ps5_q : cs5_q;
    sub6_q   <= !cz5_q && (ps5_q != cs5_q);
    d6_q     <= (dexp > 12'sd48) ? 6'd48 : dexp[5:0];
    spec6_q  <= spec5_q;
    sbits6_q <= sbits5_q;
    meta6_q  <= meta5_q;
  end

  // ---------------- stage 7: align the smaller operand with sticky
  logic lost6;
  assign lost6 = |(small6_q & ~({48{1'b1}} << d6_q));

  logic                 v7_q;
  logic [47:0]          big7_q, small7_q;
  logic signed [11:0]   be7_q;
  logic                 bs7_q, sub7_q;
  logic                 spec7_q;
  logic [31:0]          sbits7_q;
  fgemv_pkg::row_meta_t meta7_q;

  always_ff @(posedge clk_i) begin
    big7_q   <= big6_q;
    small7_q <= (small6_q >> d6_q) | {47'd0, lost6};
    be7_q    <= be6_q;
    bs7_q    <= bs6_q;
    sub7_q   <= sub6_q;
    spec7_q  <= spec6_q;
    sbits7_q <= sbits6_q;
    meta7_q  <= meta6_q;
  end

  // ---------------- stage 8: add or subtract magnitudes
  logic                 v8_q;
  logic [48:0]          r8_q;
  logic signed [11:0]   be8_q;
  logic                 bs8_q;
  logic                 spec8_q;
  logic [31:0]          sbits8_q;
  fgemv_pkg::row_meta_t meta8_q;

  always_ff @(posedge clk_i) begin
    r8_q     <= sub7_q ? ({1'b0, big7_q} - {1'b0, small7_q})
                       : ({1'b0, big7_q} + {1'b0, small7_q});
    be8_q    <= be7_q;
    bs8_q    <= bs7_q;
    spec8_q  <= spec7_q;
    sbits8_q <= sbits7_q;
    meta8_q  <= meta7_q;
  end

  // ---------------- stage 9: exponent and shift plan for rounding
  logic [5:0]         n8;
  logic signed [11:0] ex8, net8, neg8;
  logic               dir9_d;
  logic [5:0]         lsh9_d, rsh9_d;
  logic [11:0]        base9_d;

  always_comb begin
    n8      = lzc49(r8_q);
    ex8     = be8_q - $signed({6'd0, n8}) + PackBias;
    net8    = be8_q + SubNet;
    neg8    = -net8;
    dir9_d  = 1'b0;
    lsh9_d  = n8;
    rsh9_d  = 6'd0;
    base9_d = 12'd0;
    if (ex8 >= 12'sd1) begin
      base9_d = 12'(ex8 - 12'sd1);
    end else if (net8 >= 12'sd0) begin
      lsh9_d = net8[5:0];
    end else begin
      dir9_d = 1'b1;
      rsh9_d = (neg8 > 12'sd50) ? 6'd50 : neg8[5:0];
    end
  end

  logic                 v9_q;
  logic [48:0]          r9_q;
  logic                 dir9_q;
  logic [5:0]           lsh9_q, rsh9_q;
  logic [11:0]          base9_q;
  logic                 bs9_q;
  logic                 spec9_q;
  logic [31:0]          sbits9_q;
  fgemv_pkg::row_meta_t meta9_q;

  always_ff @(posedge clk_i) begin
    r9_q     <= r8_q;
    dir9_q   <= dir9_d;
    lsh9_q   <= lsh9_d;
    rsh9_q   <= rsh9_d;
    base9_q  <= base9_d;
    bs9_q    <= bs8_q;
    // exact cancellation gives positive zero
    spec9_q  <= spec8_q | (r8_q == 49'd0);
    sbits9_q <= spec8_q ? sbits8_q : 32'd0;
    meta9_q  <= meta8_q;
  end

  // ---------------- final: shift, round to nearest even, pack
  logic [48:0] shifted;
  logic        xst, grd, stk, rup, ovf;
  logic [23:0] qm;
  logic [24:0] q1;
  logic [34:0] mag;

  always_comb begin
    shifted = dir9_q ? (r9_q >> rsh9_q) : (r9_q << lsh9_q);
    xst     = dir9_q & (|(r9_q & ~({49{1'b1}} << rsh9_q)));
    qm      = shifted[48:25];
    grd     = shifted[24];
    stk     = (|shifted[23:0]) | xst;
    rup     = grd & (stk | qm[0]);
    q1      = {1'b0, qm} + {24'd0, rup};
    mag     = {base9_q, 23'd0} + {10'd0, q1};
    ovf     = mag >= {4'd0, fgemv_pkg::EXP_ALL[30:0]};
    if (spec9_q) begin
      bits_o = sbits9_q;
    end else begin
      bits_o = {bs9_q, ovf ? fgemv_pkg::EXP_ALL[30:0] : mag[30:0]};
    end
  end

  assign v_o    = v9_q;
  assign meta_o = meta9_q;
  assign busy_o = v2_q | v3_q | v4_q | v5_q;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v2_q <= v_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

endmodule

/* sv/fp32_gemv_fma_engine.sv */
// Single-precision matrix-vector product y = W * x. Load x first (action 0, one element per
// item at x_index), then stream the weights row by row (action 1); every weight is folded into
// the row sum with one fused multiply-add rounded to nearest even, and each finished row gives
// one result item with its sum, row number and a last-row flag. x loads are taken every cycle.
// Weights are not taken back to back: each waits until the previous one has left the stage that
// reads the running sum, which an add/normalize/round loop reads, combines and writes back, and
// the next weight of a row needs that sum. The weight that closes a row waits while an earlier
// result is held at the output or an earlier row end is still in flight. Writing vector_length
// or row_total restarts the pass (sum, column and row cleared); x entries are kept, and an x
// entry read before it was ever written gives an undefined result.
`timescale 1ns / 1ps

module fp32_gemv_fma_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fgemv_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fgemv_pkg::out_item_t out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned AW = fgemv_pkg::VEC_AW;
  localparam int unsigned LW = fgemv_pkg::LEN_W;

  // configuration registers
  logic [LW-1:0] vlen_q, rtot_q;
  logic [LW-1:0] neff, meff;
  logic          cfg_wr;
  logic          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = paddr[2];

  always_comb begin
    unique case (fgemv_pkg::reg_idx_e'(cfg_sel))
      fgemv_pkg::RegVecLen:   prdata = {{(32-LW){1'b0}}, vlen_q};
      fgemv_pkg::RegRowTotal: prdata = {{(32-LW){1'b0}}, rtot_q};
      default:                prdata = 32'd0;
    endcase
  end

  // clamp lengths into 1..MAX_LENGTH
  always_comb begin
    neff = (vlen_q == '0) ? LW'(1)
         : (vlen_q > LW'(fgemv_pkg::MAX_LENGTH)) ? LW'(fgemv_pkg::MAX_LENGTH) : vlen_q;
    meff = (rtot_q == '0) ? LW'(1)
         : (rtot_q > LW'(fgemv_pkg::MAX_LENGTH)) ? LW'(fgemv_pkg::MAX_LENGTH) : rtot_q;
  end

  // pass position and input acceptance
  logic [AW-1:0]        col_q;
  logic [9:0]           row_q;
  logic                 is_weight, eor, last;
  logic                 v1_q, fma_busy, eor_pend_q;
  logic                 out_v_q;
  logic                 in_acc, load_acc, wgt_acc;
  fgemv_pkg::row_meta_t meta_d;

  assign is_weight = (fgemv_pkg::action_e'(in_item_i.action) == fgemv_pkg::ActWeight);
  assign eor       = ({1'b0, col_q} + LW'(1)) >= neff;
  assign last      = ({1'b0, row_q} + LW'(1)) >= meff;
  assign meta_d    = '{eor: eor, row: row_q, last: last};

  always_comb begin
    if (is_weight) begin
      in_ready_o = !(v1_q | fma_busy) && (!eor || (!out_v_q && !eor_pend_q));
    end else begin
      in_ready_o = 1'b1;
    end
  end

  assign in_acc   = in_valid_i & in_ready_o;
  assign load_acc = in_acc & !is_weight;
  assign wgt_acc  = in_acc & is_weight;

  // vector store
  logic [31:0] vec_mem [fgemv_pkg::MAX_LENGTH];
  logic [31:0] x1_q, w1_q;
  fgemv_pkg::row_meta_t meta1_q;

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      vec_mem[in_item_i.x_index[AW-1:0]] <= in_item_i.value_bits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wgt_acc) begin
      x1_q    <= vec_mem[col_q];
      w1_q    <= in_item_i.value_bits;
      meta1_q <= meta_d;
    end
  end

  // fused multiply-add datapath
  logic                 res_v;
  logic [31:0]          res_bits;
  fgemv_pkg::row_meta_t res_meta;
  logic [31:0]          sum_q;

  fgemv_fma u_fma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (v1_q),
    .a_i    (x1_q),
    .b_i    (w1_q),
    .meta_i (meta1_q),
    .c_i    (sum_q),
    .busy_o (fma_busy),
    .v_o    (res_v),
    .bits_o (res_bits),
    .meta_o (res_meta)
  );

  // control state: config, counters, running sum, output item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q     <= LW'(fgemv_pkg::MAX_LENGTH);
      rtot_q     <= LW'(fgemv_pkg::MAX_LENGTH);
      col_q      <= '0;
      row_q      <= '0;
      sum_q      <= 32'd0;
      v1_q       <= 1'b0;
      eor_pend_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      v1_q <= wgt_acc;
      if (cfg_wr) begin
        unique case (fgemv_pkg::reg_idx_e'(cfg_sel))
          fgemv_pkg::RegVecLen:   vlen_q <= pwdata[LW-1:0];
          fgemv_pkg::RegRowTotal: rtot_q <= pwdata[LW-1:0];
          default:                vlen_q <= vlen_q;
        endcase
        col_q <= '0;
        row_q <= '0;
        sum_q <= 32'd0;
      end else begin
        if (wgt_acc) begin
          if (eor) begin
            col_q <= '0;
            row_q <= last ? 10'd0 : row_q + 10'd1;
          end else begin
            col_q <= col_q + AW'(1);
          end
        end
        if (res_v) begin
          sum_q <= res_meta.eor ? 32'd0 : res_bits;
        end
      end
      // a row end in flight reserves the output register
      if (wgt_acc && eor) begin
        eor_pend_q <= 1'b1;
      end else if (res_v && res_meta.eor) begin
        eor_pend_q <= 1'b0;
      end
      if (res_v && res_meta.eor) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // output item payload
  fgemv_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (res_v && res_meta.eor) begin
      out_q <= '{dot_bits: res_bits, row_number: res_meta.row, last_row: res_meta.last};
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

/* sim/fp32_gemv_fma_engine_tb.sv */
`timescale 1ns / 1ps

module fp32_gemv_fma_engine_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 30;

  typedef enum int {
    RowItem,
    RowSetLen,
    RowSetRows
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    fgemv_pkg::action_e act;
    logic [9:0]         idx;
    logic [31:0]        value;
    bit                 typed;
    logic [31:0]        dot;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  fgemv_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  fgemv_pkg::out_item_t out_item;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  fp32_gemv_fma_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // golden copy of the engine state
  logic [31:0]          x_store [fgemv_pkg::MAX_LENGTH];
  bit                   x_written [fgemv_pkg::MAX_LENGTH];
  logic [31:0]          row_sum;
  int unsigned          col_pos;
  int unsigned          row_pos;
  logic [10:0]          vec_len_reg;
  logic [10:0]          row_tot_reg;
  fgemv_pkg::out_item_t dot_q [$];
  int unsigned          mismatches = 0;
  int unsigned          cycles = 0;
  bit                   hold_req = 1'b0;
  int unsigned          burst_left = 0;

  // float helpers for the fused multiply-add
  function automatic int top_bit(logic [63:0] v);
    int k;
    k = 63;
    while (k > 0 && !v[k]) k--;
    return k;
  endfunction

  function automatic logic [63:0] lift(logic [63:0] v, inout int e);
    int sh;
    sh = 61 - top_bit(v);
    if (sh > 0) begin
      v = v << sh;
      e = e - sh;
    end
    return v;
  endfunction

  function automatic logic [31:0] round_pack(logic [31:0] sign, logic [63:0] r, int e);
    int s, lo, ex;
    logic [63:0] q, rem, half;
    s = top_bit(r) - 23;
    lo = -149 - e;
    if (lo > s) s = lo;
    if (s >= 64) return sign;
    if (s <= 0) begin
      q = r << (-s);
    end else begin
      rem = r & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      q = r >> s;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    ex = s + e + 150;
    if ((q >> 24) != 0) begin
      q = q >> 1;
      ex++;
    end
    if (q < (64'd1 << 23)) return sign | q[31:0];
    if (ex >= 255) return sign | fgemv_pkg::EXP_ALL;
    return sign | {1'b0, ex[7:0], q[22:0]};
  endfunction

  function automatic logic [63:0] mant_of(logic [31:0] v, output int e);
    if (v[30:23] == 8'd0) begin
      e = -149;
      return {41'd0, v[22:0]};
    end
    e = int'(v[30:23]) - 150;
    return {40'd0, 1'b1, v[22:0]};
  endfunction

  function automatic logic [31:0] fma32(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    bit anan, bnan, cnan, ainf, binf, cinf, az, bz, cz;
    logic [31:0] ps, cs, bs;
    int ea, eb, pe, ce, be, d;
    logic [63:0] pm, cm, big, lesser, r, lost;
    anan = a[30:0] > fgemv_pkg::EXP_ALL[30:0];
    bnan = b[30:0] > fgemv_pkg::EXP_ALL[30:0];
    cnan = c[30:0] > fgemv_pkg::EXP_ALL[30:0];
    ainf = a[30:0] == fgemv_pkg::EXP_ALL[30:0];
    binf = b[30:0] == fgemv_pkg::EXP_ALL[30:0];
    cinf = c[30:0] == fgemv_pkg::EXP_ALL[30:0];
    az = a[30:0] == 0;
    bz = b[30:0] == 0;
    cz = c[30:0] == 0;
    ps = {a[31] ^ b[31], 31'd0};
    cs = {c[31], 31'd0};
    if (anan || bnan || cnan) return fgemv_pkg::CANON_NAN;
    if ((ainf && bz) || (binf && az)) return fgemv_pkg::CANON_NAN;
    if (ainf || binf) begin
      if (cinf && cs != ps) return fgemv_pkg::CANON_NAN;
      return ps | fgemv_pkg::EXP_ALL;
    end
    if (cinf) return c;
    if (az || bz) return cz ? (ps & cs) : c;
    pm = mant_of(a, ea) * mant_of(b, eb);
    pe = ea + eb;
    pm = lift(pm, pe);
    if (cz) return round_pack(ps, pm, pe);
    cm = mant_of(c, ce);
    cm = lift(cm, ce);
    if (pe > ce || (pe == ce && pm >= cm)) begin
      big = pm; be = pe; bs = ps; lesser = cm; d = pe - ce;
    end else begin
      big = cm; be = ce; bs = cs; lesser = pm; d = ce - pe;
    end
    if (d >= 64) begin
      lesser = 64'd1;
    end else if (d > 0) begin
      lost = lesser & ((64'd1 << d) - 64'd1);
      lesser = (lesser >> d) | {63'd0, lost != 0};
    end
    r = (ps == cs) ? big + lesser : big - lesser;
    if (r == 0) return 32'd0;
    return round_pack(bs, r, be);
  endfunction

  function automatic int unsigned clamp_len(logic [10:0] v);
    if (v == 0) return 1;
    if (v > fgemv_pkg::MAX_LENGTH) return fgemv_pkg::MAX_LENGTH;
    return v;
  endfunction

  // fold one accepted item into the golden state, queue any row result
  task automatic predict_dot(fgemv_pkg::in_item_t it, bit typed, logic [31:0] typed_dot);
    fgemv_pkg::out_item_t res;
    if (it.action == fgemv_pkg::ActLoad) begin
      x_store[it.x_index] = it.value_bits;
      x_written[it.x_index] = 1'b1;
    end else begin
      if (col_pos >= fgemv_pkg::MAX_LENGTH) col_pos = 0;
      row_sum = fma32(x_store[col_pos], it.value_bits, row_sum);
      if (col_pos + 1 < clamp_len(vec_len_reg)) begin
        col_pos++;
      end else begin
        res.dot_bits = typed ? typed_dot : row_sum;
        res.row_number = row_pos[9:0];
        res.last_row = (row_pos + 1 >= clamp_len(row_tot_reg));
        dot_q.push_back(res);
        row_sum = 32'd0;
        col_pos = 0;
        row_pos = res.last_row ? 0 : row_pos + 1;
      end
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // sender: offer one item, hold it until taken, then maybe open a gap
  task automatic send_item(fgemv_pkg::in_item_t it, bit typed = 1'b0,
                           logic [31:0] typed_dot = '0);
    int unsigned gap;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    predict_dot(it, typed, typed_dot);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic stop_and_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (dot_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // register write: setup then access cycle
  task automatic reg_write(fgemv_pkg::reg_idx_e idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == fgemv_pkg::RegVecLen) vec_len_reg = data[10:0];
    else row_tot_reg = data[10:0];
    row_sum = 32'd0;
    col_pos = 0;
    row_pos = 0;
  endtask

  function automatic logic [31:0] rand_fp();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(15))
      0: v = {v[31], 31'd0};
      1: v = {v[31], fgemv_pkg::EXP_ALL[30:0]};
      2: v = {v[31], 8'hFF, v[22:0] | 23'd1};
      3: v = {v[31], 8'd0, v[22:0]};
      4: v = {v[31], 8'hFE, v[22:0]};
      5, 6: v = v;
      default: v = {v[31], 8'($urandom_range(140, 114)), v[22:0]};
    endcase
    return v;
  endfunction

  // random phase: mostly weights, loads ahead of any column not yet written
  task automatic run_phase(logic [10:0] n_val, logic [10:0] m_val, int unsigned count,
                           bit long_hold);
    fgemv_pkg::in_item_t it;
    int unsigned n_eff;
    stop_and_drain();
    reg_write(fgemv_pkg::RegVecLen, {21'd0, n_val});
    reg_write(fgemv_pkg::RegRowTotal, {21'd0, m_val});
    n_eff = clamp_len(n_val);
    for (int unsigned i = 0; i < count; i++) begin
      if (long_hold && i == count / 3) hold_req = 1'b1;
      if (i == count / 2) stop_and_drain();
      if ($urandom_range(99) < 15) begin
        it.action = fgemv_pkg::ActLoad;
        it.x_index = ($urandom_range(9) < 7) ? 10'($urandom_range(n_eff - 1)) : 10'($urandom);
        it.value_bits = rand_fp();
      end else begin
        if (!x_written[col_pos % fgemv_pkg::MAX_LENGTH]) begin
          it.action = fgemv_pkg::ActLoad;
          it.x_index = 10'(col_pos);
          it.value_bits = rand_fp();
          send_item(it);
        end
        it.action = fgemv_pkg::ActWeight;
        it.x_index = 10'($urandom);
        it.value_bits = rand_fp();
      end
      send_item(it);
    end
  endtask

  // directed cases
  stim_row_t stim_rows [] = '{
    '{RowSetLen,  fgemv_pkg::ActLoad,   10'd0,   32'd1,         1'b0, 32'h0},
    '{RowSetRows, fgemv_pkg::ActLoad,   10'd0,   32'd1,         1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActLoad,   10'd0,   32'h3F80_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h4000_0000, 1'b1, 32'h4000_0000},
    // infinity times zero
    '{RowItem,    fgemv_pkg::ActLoad,   10'd0,   32'h7F80_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'h3FF, 32'h0000_0000, 1'b1, 32'h7FC0_0000},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'hFF80_0000, 1'b1, 32'hFF80_0000},
    // nan operand
    '{RowItem,    fgemv_pkg::ActLoad,   10'd0,   32'h7FC0_0001, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h3F80_0000, 1'b1, 32'h7FC0_0000},
    // signed zeros
    '{RowItem,    fgemv_pkg::ActLoad,   10'd0,   32'h8000_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h0000_0000, 1'b1, 32'h0000_0000},
    // overflow
    '{RowItem,    fgemv_pkg::ActLoad,   10'd0,   32'h7F7F_FFFF, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h7F7F_FFFF, 1'b1, 32'h7F80_0000},
    // subnormal rounding, ties to even
    '{RowItem,    fgemv_pkg::ActLoad,   10'd0,   32'h0000_0001, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h3F00_0000, 1'b1, 32'h0000_0000},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h3FC0_0000, 1'b1, 32'h0000_0002},
    '{RowItem,    fgemv_pkg::ActLoad,   10'h3FF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    // three columns, two rows, load between weights
    '{RowSetLen,  fgemv_pkg::ActLoad,   10'd0,   32'd3,         1'b0, 32'h0},
    '{RowSetRows, fgemv_pkg::ActLoad,   10'd0,   32'd2,         1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActLoad,   10'd1,   32'h4040_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActLoad,   10'd2,   32'hC000_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h3F80_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h4000_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'hBF80_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h4080_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActLoad,   10'd2,   32'h3F80_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'h4000_0000, 1'b0, 32'h0},
    '{RowItem,    fgemv_pkg::ActWeight, 10'd0,   32'hC040_0000, 1'b0, 32'h0}
  };

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned mode;
    hold_left = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (cycles % 64 == 0) mode = $urandom_range(3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(1) == 0);
          2: out_ready <= ($urandom_range(3) == 0);
          default: out_ready <= ((cycles % 8) < 5);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    fgemv_pkg::out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (dot_q.size() == 0) begin
        report("unexpected result", out_item.dot_bits, 32'h0);
      end else begin
        want = dot_q.pop_front();
        if (out_item.dot_bits !== want.dot_bits)
          report("dot_bits", out_item.dot_bits, want.dot_bits);
        if (out_item.row_number !== want.row_number)
          report("row_number", 32'(out_item.row_number), 32'(want.row_number));
        if (out_item.last_row !== want.last_row)
          report("last_row", 32'(out_item.last_row), 32'(want.last_row));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    fgemv_pkg::in_item_t it;
    for (int i = 0; i < fgemv_pkg::MAX_LENGTH; i++) begin
      x_store[i] = '0;
      x_written[i] = 1'b0;
    end
    row_sum = 32'd0;
    col_pos = 0;
    row_pos = 0;
    vec_len_reg = 11'd1024;
    row_tot_reg = 11'd1024;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        RowSetLen: begin
          stop_and_drain();
          reg_write(fgemv_pkg::RegVecLen, stim_rows[i].value);
        end
        RowSetRows: begin
          stop_and_drain();
          reg_write(fgemv_pkg::RegRowTotal, stim_rows[i].value);
        end
        default: begin
          it.action = stim_rows[i].act;
          it.x_index = stim_rows[i].idx;
          it.value_bits = stim_rows[i].value;
          send_item(it, stim_rows[i].typed, stim_rows[i].dot);
        end
      endcase
    end

    // random phases, extremes among them
    run_phase(11'd3, 11'd4, 150, 1'b1);
    run_phase(11'd1, 11'd7, 80, 1'b0);
    run_phase(11'd16, 11'd3, 200, 1'b0);
    run_phase(11'd0, 11'd0, 40, 1'b0);
    run_phase(11'd1, 11'd2047, 250, 1'b0);
    run_phase(11'd1030, 11'd1, 200, 1'b0);

    stop_and_drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
